// File: rtl/pcc_pkg.sv
// shared types, constants and micro-op tables for the polygon convexity checker
// used by pcc_ctrl, pcc_datapath and polygon_convexity_check_core; no dependencies
package pcc_pkg;

   // arithmetic widths, all exact
   localparam int COORD_BITS   = 16;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int NORM_BITS    = 2 * DIFF_BITS + 1;
   localparam int EDGE_BITS    = DIFF_BITS + NORM_BITS + 1;
   localparam int PROD_BITS    = EDGE_BITS + DIFF_BITS;
   localparam int ACC_BITS     = PROD_BITS + 2;

   // vertex bookkeeping
   localparam int MAX_VERTICES = 1024;
   localparam int COUNT_BITS   = $clog2(MAX_VERTICES + 1);
   localparam int SEEN_SAT     = 4;
   localparam int SEEN_BITS    = $clog2(SEEN_SAT + 1);

   // micro-op program lengths
   localparam int NORM_STEPS   = 6;
   localparam int TEST_STEPS   = 9;
   localparam int STEP_BITS    = $clog2(TEST_STEPS);

   // result status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_SHORT = 1'b1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } vertex_type;

   typedef enum logic [3:0] {
      OPA_U0, OPA_U1, OPA_U2,
      OPA_N0, OPA_N1, OPA_N2,
      OPA_E0, OPA_E1, OPA_E2
   } a_sel_type;

   typedef enum logic [2:0] {
      OPB_U0, OPB_U1, OPB_U2,
      OPB_W0, OPB_W1, OPB_W2
   } b_sel_type;

   typedef enum logic [1:0] {
      ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB
   } acc_mode_type;

   typedef enum logic [2:0] {
      DST_NONE, DST_N0, DST_N1, DST_N2,
      DST_E0, DST_E1, DST_E2, DST_SIGN
   } dest_type;

   typedef enum logic [1:0] {
      TRI_MAIN, TRI_WRAP1, TRI_WRAP2
   } triple_type;

   typedef enum logic [1:0] {
      RES_SHORT, RES_TRI, RES_FULL
   } result_type;

   typedef struct packed {
      a_sel_type    a_sel;
      b_sel_type    b_sel;
      acc_mode_type acc_mode;
      dest_type     dest;
   } mac_op_type;

   typedef struct packed {
      logic       capture;
      logic       load_diff;
      triple_type triple;
      logic       issue;
      mac_op_type op;
      logic       finish;
      logic       take_first0;
      logic       take_first1;
      logic       publish;
      result_type result;
   } cmd_type;

   function automatic mac_op_type mk_op(input a_sel_type a, input b_sel_type b,
                                        input acc_mode_type m, input dest_type d);
      mac_op_type op;
      op.a_sel    = a;
      op.b_sel    = b;
      op.acc_mode = m;
      op.dest     = d;
      return op;
   endfunction

   // normal = u x w, u = p1 - p0, w = p2 - p1
   function automatic mac_op_type norm_op(input logic [STEP_BITS-1:0] step);
      mac_op_type op;
      op = mk_op(OPA_U0, OPB_U0, ACC_NONE, DST_NONE);
      case (step)
         4'd0:    op = mk_op(OPA_U1, OPB_W2, ACC_LOAD, DST_NONE);
         4'd1:    op = mk_op(OPA_U2, OPB_W1, ACC_SUB,  DST_N0);
         4'd2:    op = mk_op(OPA_U2, OPB_W0, ACC_LOAD, DST_NONE);
         4'd3:    op = mk_op(OPA_U0, OPB_W2, ACC_SUB,  DST_N1);
         4'd4:    op = mk_op(OPA_U0, OPB_W1, ACC_LOAD, DST_NONE);
         4'd5:    op = mk_op(OPA_U1, OPB_W0, ACC_SUB,  DST_N2);
         default: op = mk_op(OPA_U0, OPB_U0, ACC_NONE, DST_NONE);
      endcase
      return op;
   endfunction

   // e = u x normal, then sign of e . w
   function automatic mac_op_type test_op(input logic [STEP_BITS-1:0] step);
      mac_op_type op;
      op = mk_op(OPA_U0, OPB_U0, ACC_NONE, DST_NONE);
      case (step)
         4'd0:    op = mk_op(OPA_N2, OPB_U1, ACC_LOAD, DST_NONE);
         4'd1:    op = mk_op(OPA_N1, OPB_U2, ACC_SUB,  DST_E0);
         4'd2:    op = mk_op(OPA_N0, OPB_U2, ACC_LOAD, DST_NONE);
         4'd3:    op = mk_op(OPA_N2, OPB_U0, ACC_SUB,  DST_E1);
         4'd4:    op = mk_op(OPA_N1, OPB_U0, ACC_LOAD, DST_NONE);
         4'd5:    op = mk_op(OPA_N0, OPB_U1, ACC_SUB,  DST_E2);
         4'd6:    op = mk_op(OPA_E0, OPB_W0, ACC_LOAD, DST_NONE);
         4'd7:    op = mk_op(OPA_E1, OPB_W1, ACC_ADD,  DST_NONE);
         4'd8:    op = mk_op(OPA_E2, OPB_W2, ACC_ADD,  DST_SIGN);
         default: op = mk_op(OPA_U0, OPB_U0, ACC_NONE, DST_NONE);
      endcase
      return op;
   endfunction

endpackage

// File: rtl/pcc_datapath.sv
// datapath: vertex registers, edge differences, shared multiplier and accumulator
// depends on pcc_pkg; driven by command structs from pcc_ctrl
module pcc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [pcc_pkg::COORD_BITS-1:0] req_x_coord,
   input  logic signed [pcc_pkg::COORD_BITS-1:0] req_y_coord,
   input  logic signed [pcc_pkg::COORD_BITS-1:0] req_z_coord,
   input  pcc_pkg::cmd_type                    cmd,
   output logic                                rsp_is_convex_flag,
   output logic                                rsp_status,
   output logic [pcc_pkg::COUNT_BITS-1:0]      rsp_vertex_total
);

   pcc_pkg::vertex_type cur_ff, f0_ff, f1_ff, r0_ff, r1_ff;
   pcc_pkg::vertex_type a_pt, b_pt, c_pt;

   logic signed [pcc_pkg::DIFF_BITS-1:0] u_ff [3];
   logic signed [pcc_pkg::DIFF_BITS-1:0] w_ff [3];
   logic signed [pcc_pkg::DIFF_BITS-1:0] u_in [3];
   logic signed [pcc_pkg::DIFF_BITS-1:0] w_in [3];
   logic signed [pcc_pkg::NORM_BITS-1:0] n_ff [3];
   logic signed [pcc_pkg::EDGE_BITS-1:0] e_ff [3];

   logic signed [pcc_pkg::EDGE_BITS-1:0] a_mux;
   logic signed [pcc_pkg::DIFF_BITS-1:0] b_mux;
   logic signed [pcc_pkg::PROD_BITS-1:0] prod_in, prod_ff;
   logic signed [pcc_pkg::ACC_BITS-1:0]  prod_ext, acc_in, acc_ff;

   pcc_pkg::acc_mode_type acc_mode_ff;
   pcc_pkg::dest_type     dest_ff;

   logic                            convex_ff;
   logic [pcc_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic                            flag_ff, status_ff;
   logic [pcc_pkg::COUNT_BITS-1:0]  total_ff;

   function automatic logic signed [pcc_pkg::DIFF_BITS-1:0] sub_coord(
      input logic signed [pcc_pkg::COORD_BITS-1:0] hi,
      input logic signed [pcc_pkg::COORD_BITS-1:0] lo);
      return {hi[pcc_pkg::COORD_BITS-1], hi} - {lo[pcc_pkg::COORD_BITS-1], lo};
   endfunction

   function automatic logic signed [pcc_pkg::EDGE_BITS-1:0] ext_diff(
      input logic signed [pcc_pkg::DIFF_BITS-1:0] v);
      return {{(pcc_pkg::EDGE_BITS-pcc_pkg::DIFF_BITS){v[pcc_pkg::DIFF_BITS-1]}}, v};
   endfunction

   function automatic logic signed [pcc_pkg::EDGE_BITS-1:0] ext_norm(
      input logic signed [pcc_pkg::NORM_BITS-1:0] v);
      return {{(pcc_pkg::EDGE_BITS-pcc_pkg::NORM_BITS){v[pcc_pkg::NORM_BITS-1]}}, v};
   endfunction

   // triple selection for the edge differences
   always_comb begin
      unique case (cmd.triple)
         pcc_pkg::TRI_WRAP1: begin
            a_pt = r0_ff;
            b_pt = r1_ff;
            c_pt = f0_ff;
         end
         pcc_pkg::TRI_WRAP2: begin
            a_pt = r1_ff;
            b_pt = f0_ff;
            c_pt = f1_ff;
         end
         default: begin
            a_pt = r0_ff;
            b_pt = r1_ff;
            c_pt = cur_ff;
         end
      endcase
   end

   always_comb begin
      u_in[0] = sub_coord(b_pt.x, a_pt.x);
      u_in[1] = sub_coord(b_pt.y, a_pt.y);
      u_in[2] = sub_coord(b_pt.z, a_pt.z);
      w_in[0] = sub_coord(c_pt.x, b_pt.x);
      w_in[1] = sub_coord(c_pt.y, b_pt.y);
      w_in[2] = sub_coord(c_pt.z, b_pt.z);
   end

   // multiplier operands
   always_comb begin
      unique case (cmd.op.a_sel)
         pcc_pkg::OPA_U1: a_mux = ext_diff(u_ff[1]);
         pcc_pkg::OPA_U2: a_mux = ext_diff(u_ff[2]);
         pcc_pkg::OPA_N0: a_mux = ext_norm(n_ff[0]);
         pcc_pkg::OPA_N1: a_mux = ext_norm(n_ff[1]);
         pcc_pkg::OPA_N2: a_mux = ext_norm(n_ff[2]);
         pcc_pkg::OPA_E0: a_mux = e_ff[0];
         pcc_pkg::OPA_E1: a_mux = e_ff[1];
         pcc_pkg::OPA_E2: a_mux = e_ff[2];
         default:         a_mux = ext_diff(u_ff[0]);
      endcase
      unique case (cmd.op.b_sel)
         pcc_pkg::OPB_U1: b_mux = u_ff[1];
         pcc_pkg::OPB_U2: b_mux = u_ff[2];
         pcc_pkg::OPB_W0: b_mux = w_ff[0];
         pcc_pkg::OPB_W1: b_mux = w_ff[1];
         pcc_pkg::OPB_W2: b_mux = w_ff[2];
         default:         b_mux = u_ff[0];
      endcase
   end

   assign prod_in  = a_mux * b_mux;
   assign prod_ext = {{(pcc_pkg::ACC_BITS-pcc_pkg::PROD_BITS){prod_ff[pcc_pkg::PROD_BITS-1]}},
                      prod_ff};

   always_comb begin
      unique case (acc_mode_ff)
         pcc_pkg::ACC_LOAD: acc_in = prod_ext;
         pcc_pkg::ACC_ADD:  acc_in = acc_ff + prod_ext;
         pcc_pkg::ACC_SUB:  acc_in = acc_ff - prod_ext;
         default:           acc_in = acc_ff;
      endcase
   end

   assign count_in = (count_ff == pcc_pkg::COUNT_BITS'(pcc_pkg::MAX_VERTICES)) ?
                     count_ff : count_ff + pcc_pkg::COUNT_BITS'(1);

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_ff.x <= req_x_coord;
         cur_ff.y <= req_y_coord;
         cur_ff.z <= req_z_coord;
      end
      if (cmd.finish) begin
         r0_ff <= r1_ff;
         r1_ff <= cur_ff;
         if (cmd.take_first0) f0_ff <= cur_ff;
         if (cmd.take_first1) f1_ff <= cur_ff;
      end
      if (cmd.load_diff) begin
         for (int k = 0; k < 3; k++) begin
            u_ff[k] <= u_in[k];
            w_ff[k] <= w_in[k];
         end
      end
      if (cmd.issue) begin
         prod_ff <= prod_in;
         dest_ff <= cmd.op.dest;
      end
      if (acc_mode_ff != pcc_pkg::ACC_NONE) begin
         acc_ff <= acc_in;
         case (dest_ff)
            pcc_pkg::DST_N0: n_ff[0] <= acc_in[pcc_pkg::NORM_BITS-1:0];
            pcc_pkg::DST_N1: n_ff[1] <= acc_in[pcc_pkg::NORM_BITS-1:0];
            pcc_pkg::DST_N2: n_ff[2] <= acc_in[pcc_pkg::NORM_BITS-1:0];
            pcc_pkg::DST_E0: e_ff[0] <= acc_in[pcc_pkg::EDGE_BITS-1:0];
            pcc_pkg::DST_E1: e_ff[1] <= acc_in[pcc_pkg::EDGE_BITS-1:0];
            pcc_pkg::DST_E2: e_ff[2] <= acc_in[pcc_pkg::EDGE_BITS-1:0];
            default: ;
         endcase
      end
      if (cmd.publish) begin
         flag_ff   <= (cmd.result == pcc_pkg::RES_FULL) ? convex_ff :
                      (cmd.result == pcc_pkg::RES_TRI);
         status_ff <= (cmd.result == pcc_pkg::RES_SHORT) ? pcc_pkg::STATUS_SHORT :
                      pcc_pkg::STATUS_OK;
         total_ff  <= count_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_mode_ff <= pcc_pkg::ACC_NONE;
         convex_ff   <= 1'b1;
         count_ff    <= '0;
      end else begin
         acc_mode_ff <= cmd.issue ? cmd.op.acc_mode : pcc_pkg::ACC_NONE;
         if (cmd.publish) begin
            convex_ff <= 1'b1;
            count_ff  <= '0;
         end else begin
            // a test value of zero or above breaks convexity
            if (acc_mode_ff != pcc_pkg::ACC_NONE && dest_ff == pcc_pkg::DST_SIGN &&
                !acc_in[pcc_pkg::ACC_BITS-1])
               convex_ff <= 1'b0;
            if (cmd.finish) count_ff <= count_in;
         end
      end
   end

   assign rsp_is_convex_flag = flag_ff;
   assign rsp_status         = status_ff;
   assign rsp_vertex_total   = total_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pcc_pkg::COUNT_BITS'(pcc_pkg::MAX_VERTICES))
      else $error("vertex count beyond maximum");
   a_publish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> (convex_ff && count_ff == '0))
      else $error("polygon state not cleared after result");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !cmd.load_diff && !cmd.finish)
      else $error("multiply issued during vertex update");
`endif

endmodule

// File: rtl/pcc_ctrl.sv
// controller: per-vertex sequencing of difference load, normal and test programs
// depends on pcc_pkg; drives pcc_datapath through cmd_type
module pcc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last_vertex,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pcc_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_DIFF   = 8'b0000_0010,
      S_NORM   = 8'b0000_0100,
      S_NWAIT  = 8'b0000_1000,
      S_TEST   = 8'b0001_0000,
      S_DRAIN  = 8'b0010_0000,
      S_FINISH = 8'b0100_0000,
      S_RESULT = 8'b1000_0000
   } state_type;

   state_type                      state_ff, state_in;
   logic [pcc_pkg::SEEN_BITS-1:0]  seen_ff, seen_in, seen_next;
   logic [pcc_pkg::STEP_BITS-1:0]  step_ff, step_in;
   logic                           last_ff, last_in;
   pcc_pkg::triple_type            pass_ff, pass_in;
   pcc_pkg::result_type            result_ff, result_in;
   logic                           out_full_ff, out_full_in;

   assign seen_next = (seen_ff == pcc_pkg::SEEN_BITS'(pcc_pkg::SEEN_SAT)) ?
                      seen_ff : seen_ff + pcc_pkg::SEEN_BITS'(1);

   always_comb begin
      state_in        = state_ff;
      seen_in         = seen_ff;
      step_in         = step_ff;
      last_in         = last_ff;
      pass_in         = pass_ff;
      result_in       = result_ff;
      cmd             = '0;
      cmd.triple      = pass_ff;
      cmd.op          = pcc_pkg::test_op(step_ff);
      cmd.result      = result_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               last_in     = req_last_vertex;
               pass_in     = pcc_pkg::TRI_MAIN;
               state_in    = (seen_ff >= pcc_pkg::SEEN_BITS'(2)) ? S_DIFF : S_FINISH;
            end
         end
         S_DIFF: begin
            cmd.load_diff = 1'b1;
            step_in       = '0;
            state_in      = (pass_ff == pcc_pkg::TRI_MAIN &&
                             seen_ff == pcc_pkg::SEEN_BITS'(2)) ? S_NORM : S_TEST;
         end
         S_NORM: begin
            cmd.issue = 1'b1;
            cmd.op    = pcc_pkg::norm_op(step_ff);
            if (step_ff == pcc_pkg::STEP_BITS'(pcc_pkg::NORM_STEPS - 1)) begin
               state_in = S_NWAIT;
            end else begin
               step_in = step_ff + pcc_pkg::STEP_BITS'(1);
            end
         end
         S_NWAIT: begin
            step_in  = '0;
            state_in = S_TEST;
         end
         S_TEST: begin
            cmd.issue = 1'b1;
            if (step_ff == pcc_pkg::STEP_BITS'(pcc_pkg::TEST_STEPS - 1)) begin
               state_in = S_DRAIN;
            end else begin
               step_in = step_ff + pcc_pkg::STEP_BITS'(1);
            end
         end
         S_DRAIN: begin
            unique case (pass_ff)
               pcc_pkg::TRI_WRAP1: begin
                  pass_in  = pcc_pkg::TRI_WRAP2;
                  state_in = S_DIFF;
               end
               pcc_pkg::TRI_WRAP2: begin
                  // last sign lands in the convex flag at this edge
                  result_in = pcc_pkg::RES_FULL;
                  state_in  = S_RESULT;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_FINISH: begin
            cmd.finish      = 1'b1;
            cmd.take_first0 = (seen_ff == '0);
            cmd.take_first1 = (seen_ff == pcc_pkg::SEEN_BITS'(1));
            seen_in         = seen_next;
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (seen_next == pcc_pkg::SEEN_BITS'(pcc_pkg::SEEN_SAT)) begin
               pass_in  = pcc_pkg::TRI_WRAP1;
               state_in = S_DIFF;
            end else begin
               result_in = (seen_next == pcc_pkg::SEEN_BITS'(3)) ?
                           pcc_pkg::RES_TRI : pcc_pkg::RES_SHORT;
               state_in  = S_RESULT;
            end
         end
         S_RESULT: begin
            // publish once the output register is free or being emptied
            if (!out_full_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               seen_in     = '0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign out_full_in = cmd.publish ? 1'b1 : (rsp_ready ? 1'b0 : out_full_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         seen_ff     <= '0;
         step_ff     <= '0;
         last_ff     <= 1'b0;
         pass_ff     <= pcc_pkg::TRI_MAIN;
         result_ff   <= pcc_pkg::RES_SHORT;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         seen_ff     <= seen_in;
         step_ff     <= step_in;
         last_ff     <= last_in;
         pass_ff     <= pass_in;
         result_ff   <= result_in;
         out_full_ff <= out_full_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_full_ff;

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn before transaction");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid || rsp_ready))
      else $error("result published over a pending one");
   a_publish_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid)
      else $error("result not presented after publish");
   a_publish_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> (req_ready && seen_ff == '0))
      else $error("position not cleared after publish");
   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= pcc_pkg::SEEN_BITS'(pcc_pkg::SEEN_SAT))
      else $error("vertex position out of range");
`endif

endmodule

// File: rtl/polygon_convexity_check_core.sv
// polygon convexity checker: one vertex per input transaction, one result per polygon
// per vertex: vertices 0 and 1 are stored; vertex 2 and later run a 9-product triple
// test, vertex 2 a 6-product normal first, on one shared 53x17 multiplier; no overlap
// end of polygon: the result is staged, after two wrap tests at 4+ vertices;
// the next polygon streams in while a result waits, until its own result is due
// reset (synchronous, active high) empties the polygon state and the result register
module polygon_convexity_check_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // vertex input
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [pcc_pkg::COORD_BITS-1:0] req_x_coord,
   input  logic signed [pcc_pkg::COORD_BITS-1:0] req_y_coord,
   input  logic signed [pcc_pkg::COORD_BITS-1:0] req_z_coord,
   input  logic                                  req_last_vertex,
   // polygon result
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_is_convex_flag,
   output logic                                  rsp_status,
   output logic [pcc_pkg::COUNT_BITS-1:0]        rsp_vertex_total
);

   // command bundle from sequencer to datapath
   pcc_pkg::cmd_type cmd;

   // sequencer: vertex position, program steps, result transaction
   pcc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_vertex (req_last_vertex),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd)
   );

   // datapath: stored vertices, normal, edge products and result fields
   pcc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_x_coord        (req_x_coord),
      .req_y_coord        (req_y_coord),
      .req_z_coord        (req_z_coord),
      .cmd                (cmd),
      .rsp_is_convex_flag (rsp_is_convex_flag),
      .rsp_status         (rsp_status),
      .rsp_vertex_total   (rsp_vertex_total)
   );

endmodule

// File: verif/tb_polygon_convexity_check_core.sv
`timescale 1ns / 1ps
// self-checking testbench for polygon_convexity_check_core: streams polygon vertices,
// predicts each polygon verdict with exact wide integer math and checks every result
// depends on pcc_pkg and the core rtl
module tb_polygon_convexity_check_core;

   // 96 bits hold every intermediate exactly (dot products need about 72)
   typedef logic signed [95:0] wide_type;
   typedef struct packed {
      logic [95:0] x;
      logic [95:0] y;
      logic [95:0] z;
   } wvec_type;

   typedef struct {
      pcc_pkg::vertex_type pos;
      logic                is_last;
   } vertex_item_type;

   typedef struct {
      logic                           convex;
      logic                           status;
      logic [pcc_pkg::COUNT_BITS-1:0] total;
   } verdict_type;

   // kinds of generated polygon
   typedef enum {SHAPE_CONVEX, SHAPE_DENT, SHAPE_DUP} shape_type;

   logic                                  clock           = 1'b0;
   logic                                  reset           = 1'b1;
   logic                                  req_valid       = 1'b0;
   logic                                  req_ready;
   logic signed [pcc_pkg::COORD_BITS-1:0] req_x_coord     = '0;
   logic signed [pcc_pkg::COORD_BITS-1:0] req_y_coord     = '0;
   logic signed [pcc_pkg::COORD_BITS-1:0] req_z_coord     = '0;
   logic                                  req_last_vertex = 1'b0;
   logic                                  rsp_valid;
   logic                                  rsp_ready       = 1'b0;
   logic                                  rsp_is_convex_flag;
   logic                                  rsp_status;
   logic [pcc_pkg::COUNT_BITS-1:0]        rsp_vertex_total;

   polygon_convexity_check_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_x_coord        (req_x_coord),
      .req_y_coord        (req_y_coord),
      .req_z_coord        (req_z_coord),
      .req_last_vertex    (req_last_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_convex_flag (rsp_is_convex_flag),
      .rsp_status         (rsp_status),
      .rsp_vertex_total   (rsp_vertex_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // vertex stream and verdict bookkeeping
   vertex_item_type pending_vertices[$];
   verdict_type     expected_verdicts[$];
   vertex_item_type in_flight;
   verdict_type     want;
   int              queued_vertices   = 0;
   int              accepted_vertices = 0;
   int              verdicts_checked  = 0;
   int              fail_count        = 0;
   int              send_gap          = 0;
   int              stall_left        = 0;
   int              hold_left         = 0;
   bit              hold_done         = 1'b0;
   logic            quiet_tail        = 1'b0;

   // convexity predictor state, cleared after each polygon
   pcc_pkg::vertex_type first_pt0, first_pt1;
   pcc_pkg::vertex_type back_pt0, back_pt1;
   wvec_type            normal_vec;
   logic                convex_run = 1'b1;
   int                  vtx_count  = 0;
   int                  pos_index  = 0;

   function automatic wvec_type vec_sub(pcc_pkg::vertex_type to_pt,
                                        pcc_pkg::vertex_type from_pt);
      wvec_type r;
      r.x = $signed(to_pt.x) - $signed(from_pt.x);
      r.y = $signed(to_pt.y) - $signed(from_pt.y);
      r.z = $signed(to_pt.z) - $signed(from_pt.z);
      return r;
   endfunction

   function automatic wvec_type cross_of(wvec_type a, wvec_type b);
      wvec_type r;
      r.x = $signed(a.y) * $signed(b.z) - $signed(a.z) * $signed(b.y);
      r.y = $signed(a.z) * $signed(b.x) - $signed(a.x) * $signed(b.z);
      r.z = $signed(a.x) * $signed(b.y) - $signed(a.y) * $signed(b.x);
      return r;
   endfunction

   // ((b - a) x n) . (c - b) strictly below zero
   function automatic logic turn_negative(pcc_pkg::vertex_type a, pcc_pkg::vertex_type b,
                                          pcc_pkg::vertex_type c, wvec_type n);
      wvec_type e;
      wvec_type w;
      wide_type d;
      e = cross_of(vec_sub(b, a), n);
      w = vec_sub(c, b);
      d = $signed(e.x) * $signed(w.x) + $signed(e.y) * $signed(w.y)
        + $signed(e.z) * $signed(w.z);
      return d < 0;
   endfunction

   task automatic predict_vertex(input vertex_item_type it);
      verdict_type v;
      if (pos_index == 0) begin
         first_pt0 = it.pos;
      end else if (pos_index == 1) begin
         first_pt1 = it.pos;
      end else if (pos_index == 2) begin
         normal_vec = cross_of(vec_sub(first_pt1, first_pt0), vec_sub(it.pos, first_pt1));
         if (!turn_negative(first_pt0, first_pt1, it.pos, normal_vec)) convex_run = 1'b0;
      end else if (!turn_negative(back_pt0, back_pt1, it.pos, normal_vec)) begin
         convex_run = 1'b0;
      end
      back_pt0 = back_pt1;
      back_pt1 = it.pos;
      if (pos_index < 4) pos_index++;
      if (vtx_count < pcc_pkg::MAX_VERTICES) vtx_count++;
      if (it.is_last) begin
         if (pos_index < 3) begin
            v.convex = 1'b0;
            v.status = pcc_pkg::STATUS_SHORT;
         end else if (pos_index == 3) begin
            // triangles pass whatever their shape
            v.convex = 1'b1;
            v.status = pcc_pkg::STATUS_OK;
         end else begin
            // the two triples that wrap around to the first vertices
            if (!turn_negative(back_pt0, back_pt1, first_pt0, normal_vec)) convex_run = 1'b0;
            if (!turn_negative(back_pt1, first_pt0, first_pt1, normal_vec)) convex_run = 1'b0;
            v.convex = convex_run;
            v.status = pcc_pkg::STATUS_OK;
         end
         v.total = vtx_count[pcc_pkg::COUNT_BITS-1:0];
         expected_verdicts.push_back(v);
         convex_run = 1'b1;
         vtx_count  = 0;
         pos_index  = 0;
      end
   endtask

   function automatic int rnd_between(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   task automatic push_vertex(input int x, input int y, input int z, input logic is_last);
      vertex_item_type it;
      it.pos.x   = x[pcc_pkg::COORD_BITS-1:0];
      it.pos.y   = y[pcc_pkg::COORD_BITS-1:0];
      it.pos.z   = z[pcc_pkg::COORD_BITS-1:0];
      it.is_last = is_last;
      pending_vertices.push_back(it);
      queued_vertices++;
   endtask

   // full-range coordinates, so every input bit toggles
   task automatic add_noise_polygon(input int n);
      int k;
      for (k = 0; k < n; k++) push_vertex($urandom(), $urandom(), $urandom(), k == n - 1);
   endtask

   // polygon on a tilted plane: circle points mapped by o + a*u + b*v
   task automatic add_planar_polygon(input int n, input shape_type shape);
      int  ox, oy, oz, u0, u1, u2, v0, v1, v2;
      int  radius, odd_at, a, b, k, px, py, pz;
      real phase, step_ang, ang;
      ox = rnd_between(-8000, 8000);
      oy = rnd_between(-8000, 8000);
      oz = rnd_between(-8000, 8000);
      do begin
         u0 = rnd_between(-3, 3);
         u1 = rnd_between(-3, 3);
         u2 = rnd_between(-3, 3);
         v0 = rnd_between(-3, 3);
         v1 = rnd_between(-3, 3);
         v2 = rnd_between(-3, 3);
      end while (u1 * v2 == u2 * v1 && u2 * v0 == u0 * v2 && u0 * v1 == u1 * v0);
      radius   = rnd_between(50, 1000);
      phase    = $urandom_range(6283) / 1000.0;
      step_ang = 6.2831853 / n * ($urandom_range(1) ? 1.0 : -1.0);
      odd_at   = $urandom_range(n - 1);
      for (k = 0; k < n; k++) begin
         ang = phase + step_ang * k;
         a   = int'(radius * $cos(ang));
         b   = int'(radius * $sin(ang));
         // pull one vertex toward the center to make a dent
         if (shape == SHAPE_DENT && k == odd_at) begin
            a = a / 4;
            b = b / 4;
         end
         px = ox + a * u0 + b * v0;
         py = oy + a * u1 + b * v1;
         pz = oz + a * u2 + b * v2;
         // a repeated vertex gives a zero edge, hence a zero product
         if (shape == SHAPE_DUP && k == odd_at) push_vertex(px, py, pz, 1'b0);
         push_vertex(px, py, pz, k == n - 1);
      end
   endtask

   // driver: one vertex transaction at a time, random gaps except near the end
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_vertex(in_flight);
            accepted_vertices++;
         end
         // payload may change only once the current transaction is gone
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_vertices.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(5) == 0) begin
               send_gap  = $urandom_range(8);
               req_valid <= 1'b0;
            end else begin
               in_flight = pending_vertices.pop_front();
               req_x_coord     <= in_flight.pos.x;
               req_y_coord     <= in_flight.pos.y;
               req_z_coord     <= in_flight.pos.z;
               req_last_vertex <= in_flight.is_last;
               req_valid       <= 1'b1;
            end
         end
         quiet_tail <= pending_vertices.size() < 150;
      end
   end

   // monitor: checks each result transaction against the oldest predicted verdict
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: convex %0b status %0b total %0d",
                           rsp_is_convex_flag, rsp_status, rsp_vertex_total);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_is_convex_flag !== want.convex || rsp_status !== want.status ||
                   rsp_vertex_total !== want.total) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result %0d: want %0b/%0b/%0d got %0b/%0b/%0d",
                              verdicts_checked, want.convex, want.status, want.total,
                              rsp_is_convex_flag, rsp_status, rsp_vertex_total);
               end
               verdicts_checked++;
            end
         end
         // one long hold-off so the core fills up and stalls its input
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && verdicts_checked >= 20) begin
            hold_done = 1'b1;
            hold_left = 399;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(4) == 0) begin
            stall_left = $urandom_range(8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int pick;

      // directed: short polygons at the coordinate extremes
      push_vertex(-32768, -32768, -32768, 1'b1);
      push_vertex(32767, 32767, 32767, 1'b0);
      push_vertex(-32768, 0, 32767, 1'b1);
      // collinear triangle still counts as convex
      push_vertex(0, 0, 0, 1'b0);
      push_vertex(1, 1, 1, 1'b0);
      push_vertex(2, 2, 2, 1'b1);
      // convex square
      push_vertex(0, 0, 0, 1'b0);
      push_vertex(100, 0, 0, 1'b0);
      push_vertex(100, 100, 0, 1'b0);
      push_vertex(0, 100, 0, 1'b1);
      // dart, concave at the third vertex
      push_vertex(0, 0, 0, 1'b0);
      push_vertex(200, 0, 0, 1'b0);
      push_vertex(50, 50, 0, 1'b0);
      push_vertex(0, 200, 0, 1'b1);
      // collinear start: zero normal makes every product zero, so not convex
      push_vertex(0, 0, 5, 1'b0);
      push_vertex(10, 0, 5, 1'b0);
      push_vertex(20, 0, 5, 1'b0);
      push_vertex(20, 20, 5, 1'b0);
      push_vertex(0, 20, 5, 1'b1);
      // skewed quad spanning the full range, widest intermediates
      push_vertex(-32768, -32768, 32767, 1'b0);
      push_vertex(32767, -32768, -32768, 1'b0);
      push_vertex(32767, 32767, 32767, 1'b0);
      push_vertex(-32768, 32767, -32768, 1'b1);

      // random: mostly well-formed planar polygons, some dented, duplicated or noise
      while (queued_vertices < 900) begin
         pick = $urandom_range(99);
         if (pick < 55)      add_planar_polygon(rnd_between(3, 12), SHAPE_CONVEX);
         else if (pick < 72) add_planar_polygon(rnd_between(4, 12), SHAPE_DENT);
         else if (pick < 80) add_planar_polygon(rnd_between(3, 10), SHAPE_DUP);
         else if (pick < 92) add_noise_polygon(rnd_between(3, 8));
         else                add_noise_polygon(rnd_between(1, 2));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (accepted_vertices != queued_vertices) @(posedge clock);
      while (expected_verdicts.size() != 0) @(posedge clock);
      // catch any stray result after the last expected one
      repeat (40) @(posedge clock);
      if (fail_count == 0 && expected_verdicts.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
